// ----- rtl/sha1bh_pkg.sv -----
// ----------------------------------------------------------------------------
// sha1bh_pkg: shared types, constants and helpers for the SHA-1 block hash
// Word and index types, the round constants, the initial chaining value,
// the sequencer state and the control bundle passed between the modules.
// ----------------------------------------------------------------------------
package sha1bh_pkg;

    localparam int WordW     = 32;
    localparam int NumWords  = 16;
    localparam int NumRounds = 80;
    localparam int CvWords   = 5;
    localparam int RoundW    = 7;
    localparam int CountW    = 4;
    localparam int IdxW      = 3;

    typedef logic [WordW-1:0]                t_word;
    typedef logic [CvWords-1:0][WordW-1:0]   t_cv;
    typedef logic [NumWords-1:0][WordW-1:0]  t_win;
    typedef logic [RoundW-1:0]               t_round;
    typedef logic [CountW-1:0]               t_wcount;
    typedef logic [IdxW-1:0]                 t_didx;

    localparam t_round  LastRound = t_round'(NumRounds - 1);
    localparam t_wcount LastWord  = t_wcount'(NumWords - 1);
    localparam t_didx   LastIdx   = t_didx'(CvWords - 1);

    // Round group boundaries
    localparam t_round Round20 = t_round'(20);
    localparam t_round Round40 = t_round'(40);
    localparam t_round Round60 = t_round'(60);

    localparam t_word K0 = 32'h5a827999;
    localparam t_word K1 = 32'h6ed9eba1;
    localparam t_word K2 = 32'h8f1bbcdc;
    localparam t_word K3 = 32'hca62c1d6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FEED,
        ST_OUT
    } t_state;

    // Control bundle from the sequencer to the datapath
    typedef struct packed {
        logic   push;     // shift an accepted word into the window
        logic   iv_load;  // reload the chaining value with the initial value
        logic   load;     // copy the chaining value into the working variables
        logic   step;     // run one round and expand one schedule word
        logic   feed;     // add the working variables into the chaining value
        t_round round;    // current round number
    } t_ctl;

    function automatic t_word iv_word(input t_didx idx);
        t_word v;
        unique case (idx)
            3'd0:    v = 32'h67452301;
            3'd1:    v = 32'hefcdab89;
            3'd2:    v = 32'h98badcfe;
            3'd3:    v = 32'h10325476;
            3'd4:    v = 32'hc3d2e1f0;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic t_word rotl1(input t_word x);
        return {x[WordW-2:0], x[WordW-1]};
    endfunction

    function automatic t_word rotl5(input t_word x);
        return {x[WordW-6:0], x[WordW-1:WordW-5]};
    endfunction

    function automatic t_word rotl30(input t_word x);
        return {x[1:0], x[WordW-1:2]};
    endfunction

endpackage

// ----- rtl/sha1bh_sched.sv -----
// ----------------------------------------------------------------------------
// sha1bh_sched: message schedule window
// Sixteen-word shift line. Accepted words shift in from the top; during the
// rounds the oldest word feeds the round and the expanded word shifts in.
// ----------------------------------------------------------------------------
module sha1bh_sched (
    input  logic              i_clk,
    input  sha1bh_pkg::t_ctl  i_ctl,
    input  sha1bh_pkg::t_word i_word,
    output sha1bh_pkg::t_word o_w
);
    import sha1bh_pkg::*;

    t_win  r_win;
    t_word expand;

    // W[t+16] = rotl1(W[t+13] ^ W[t+8] ^ W[t+2] ^ W[t])
    assign expand = rotl1(r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0]);
    assign o_w    = r_win[0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_win <= {i_word, r_win[NumWords-1:1]};
        end else if (i_ctl.step) begin
            r_win <= {expand, r_win[NumWords-1:1]};
        end
    end

endmodule

// ----- rtl/sha1bh_core.sv -----
// ----------------------------------------------------------------------------
// sha1bh_core: shared round unit
// Holds the working variables a..e and applies one SHA-1 round per step.
// ----------------------------------------------------------------------------
module sha1bh_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sha1bh_pkg::t_ctl  i_ctl,
    input  sha1bh_pkg::t_word i_w,
    input  sha1bh_pkg::t_cv   i_cv,
    output sha1bh_pkg::t_cv   o_vars
);
    import sha1bh_pkg::*;

    t_cv   r_vars;
    t_word f_val;
    t_word k_val;
    t_word t_val;
    t_word va, vb, vc, vd, ve;

    assign va = r_vars[0];
    assign vb = r_vars[1];
    assign vc = r_vars[2];
    assign vd = r_vars[3];
    assign ve = r_vars[4];

    always_comb begin
        priority if (i_ctl.round < Round20) begin
            f_val = (vb & vc) | (~vb & vd);
            k_val = K0;
        end else if (i_ctl.round < Round40) begin
            f_val = vb ^ vc ^ vd;
            k_val = K1;
        end else if (i_ctl.round < Round60) begin
            f_val = (vb & vc) | (vb & vd) | (vc & vd);
            k_val = K2;
        end else begin
            f_val = vb ^ vc ^ vd;
            k_val = K3;
        end
    end

    assign t_val  = rotl5(va) + f_val + ve + k_val + i_w;
    assign o_vars = r_vars;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vars <= '0;
        end else if (i_ctl.load) begin
            r_vars <= i_cv;
        end else if (i_ctl.step) begin
            r_vars <= {vd, vc, rotl30(vb), va, t_val};
        end
    end

endmodule

// ----- rtl/sha1bh_ctrl.sv -----
// ----------------------------------------------------------------------------
// sha1bh_ctrl: sequencer
// Counts words into a block, runs the 80 rounds, triggers the feed-forward
// and, at end of message, walks the five digest words out.
// ----------------------------------------------------------------------------
module sha1bh_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_start,
    input  logic              i_in_end,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output sha1bh_pkg::t_didx o_idx,
    output sha1bh_pkg::t_ctl  o_ctl
);
    import sha1bh_pkg::*;

    t_state  r_state,  n_state;
    t_wcount r_wcount, n_wcount;
    t_round  r_round,  n_round;
    logic    r_end,    n_end;
    t_didx   r_idx,    n_idx;
    t_wcount pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_wcount <= '0;
            r_round  <= '0;
            r_end    <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_wcount <= n_wcount;
            r_round  <= n_round;
            r_end    <= n_end;
            r_idx    <= n_idx;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_wcount    = r_wcount;
        n_round     = r_round;
        n_end       = r_end;
        n_idx       = r_idx;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_ctl       = '0;
        o_ctl.round = r_round;
        pos         = i_in_start ? '0 : r_wcount;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.push    = 1'b1;
                    o_ctl.iv_load = i_in_start;
                    n_wcount      = pos + t_wcount'(1);
                    if (pos == LastWord) begin
                        o_ctl.load = 1'b1;
                        n_end      = i_in_end;
                        n_round    = '0;
                        n_state    = ST_ROUND;
                    end
                end
            end
            ST_ROUND: begin
                o_ctl.step = 1'b1;
                n_round    = r_round + t_round'(1);
                if (r_round == LastRound) begin
                    n_state = ST_FEED;
                end
            end
            ST_FEED: begin
                o_ctl.feed = 1'b1;
                n_idx      = '0;
                n_state    = r_end ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (r_idx == LastIdx) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + t_didx'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_idx = r_idx;

endmodule

// ----- rtl/sha1_block_hash.sv -----
// ----------------------------------------------------------------------------
// sha1_block_hash: SHA-1 compression over a padded word stream
// Slave stream: tdata = 32-bit big-endian message word, tuser = start of
// message (reload the initial chaining value, word becomes word 0 of a
// block), tlast = end of message (set on word 15 of the final block).
// Master stream: five transfers per digest, H0 first; tdata = digest word,
// tuser = word index 0..4, tlast marks index 4.
// Words 0..14 of a block shift into the schedule window as accepted. The
// sixteenth word starts the compression: one round per cycle on the shared
// round unit, then a feed-forward into the chaining value. With end of
// message the digest words follow right after the feed-forward, one per
// cycle while the receiver takes them. The block is not ready during rounds,
// during the feed-forward or while digest words are pending; a stalled
// receiver holds the digest in place.
// Reset loads the standard initial value, clears the word position and
// returns the sequencer to idle. Without a start flag, words keep chaining
// from the current value, also after a digest has been sent.
// ----------------------------------------------------------------------------
module sha1_block_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] msg_word
    input  logic        s_axis_tuser,   // [0] start_message
    input  logic        s_axis_tlast,   // end_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] digest_index
    output logic        m_axis_tlast    // digest_last
);
    import sha1bh_pkg::*;

    t_ctl  ctl;
    t_word w_cur;
    t_cv   vars;
    t_cv   r_cv;
    t_didx idx;

    // Sequencer: word position, round counter, digest walk
    sha1bh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_start  (s_axis_tuser),
        .i_in_end    (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_idx       (idx),
        .o_ctl       (ctl)
    );

    // Schedule window: loaded by transfers, expanded during rounds
    sha1bh_sched u_sched (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_word (s_axis_tdata),
        .o_w    (w_cur)
    );

    // Round unit with working variables a..e
    sha1bh_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_w     (w_cur),
        .i_cv    (r_cv),
        .o_vars  (vars)
    );

    // Chaining value: reload on start, add working variables after round 79
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CvWords; i++) begin
                r_cv[i] <= iv_word(t_didx'(i));
            end
        end else if (ctl.iv_load) begin
            for (int i = 0; i < CvWords; i++) begin
                r_cv[i] <= iv_word(t_didx'(i));
            end
        end else if (ctl.feed) begin
            for (int i = 0; i < CvWords; i++) begin
                r_cv[i] <= r_cv[i] + vars[i];
            end
        end
    end

    // Digest words come straight from the chaining registers, which hold
    // still until the last word is taken
    assign m_axis_tdata = r_cv[idx];
    assign m_axis_tuser = idx;
    assign m_axis_tlast = (idx == LastIdx);

endmodule

// ----- rtl/sha1bh_checker.sv -----
// ----------------------------------------------------------------------------
// sha1bh_checker: port-level checks for the SHA-1 block hash
// Watches the two stream channels and the digest word sequence.
// ----------------------------------------------------------------------------
module sha1bh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // Hold a pending digest word until it transfers
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("digest word dropped before transfer");

    // Never take message words while digest words are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while digest pending");

    // Last flag marks exactly index four
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd4)))
        else $error("digest last flag does not match index");

    // Advance the index by one after each non-last transfer
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 3'd1))
        else $error("digest index out of sequence");

    // Drop valid after the last digest word transfers
    a_end_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
        else $error("extra digest word after last");

endmodule

bind sha1_block_hash sha1bh_checker u_sha1bh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
